// ===== src/three_channel_incremental_pid_speed_assert.svh =====
// Assertion macros for the three-channel incremental PID speed block
`ifndef THREE_CHANNEL_INCREMENTAL_PID_SPEED_ASSERT_SVH
`define THREE_CHANNEL_INCREMENTAL_PID_SPEED_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low
`define TCIPS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcips: same-cycle check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low
`define TCIPS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcips: next-cycle check failed");

`endif

// ===== src/tcips_pkg.sv =====
// Shared types and constants of the incremental PID speed block
`default_nettype none

package tcips_pkg;

    localparam int CHANNELS    = 3;
    localparam int TARGET_BITS = 12;
    localparam int LIMIT_BITS  = 24;
    localparam int DRIVE_BITS  = 8;
    localparam int ERR_BITS    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_BITS    = 34;
    localparam int CFG_BITS    = LIMIT_BITS;
    localparam int CFG_IDX_BITS = $clog2(2 * CHANNELS);

    localparam int ERR_MAX = 32767;
    localparam int ERR_MIN = -32768;

    // Q0.16 gains
    localparam logic signed [15:0] GAIN_P = 16'sd16384;
    localparam logic signed [15:0] GAIN_I = 16'sd16;
    localparam logic signed [15:0] GAIN_D = 16'sd819;

    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = 8'd255;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        logic trip;
    } lane_stat_t;

    typedef struct packed {
        logic [CHANNELS-1:0][DRIVE_BITS-1:0] drive;
        dir_t [CHANNELS-1:0]                 dir;
        logic                                reached;
    } result_t;

    function automatic dir_t dir_of(input logic signed [TARGET_BITS-1:0] target);
        dir_t d;
        if (target == '0)
            d = DIR_STOP;
        else if (target[TARGET_BITS-1])
            d = DIR_CCW;
        else
            d = DIR_CW;
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/three_channel_incremental_pid_speed.sv =====
// Three-channel incremental PID speed controller, top level
//
// Input channel: in_valid/in_stall carry edge_0..edge_2, tick and start_req.
// A transfer takes place when in_valid is high and in_stall is low. Each
// transfer yields exactly one result on out_valid/out_stall: drive_0..2,
// direction_0..2 and distance_reached.
// The result is registered in the output buffer. Throughput: one item
// per cycle while in_stall is low. Each lane finishes its count and PID
// update within the cycle of the transfer, so a tick may follow a tick.
// Configuration: cfg_we writes register cfg_index (targets 0..2, then
// distance limits 0..2); write only while the block is idle.
// Reset clears all counts, errors, drives and the arm flag; directions stop.
// Receiver stall: the result register holds, one more result goes to a
// skid entry, and in_stall rises until the skid entry drains.
`default_nettype none

module three_channel_incremental_pid_speed #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tcips_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tcips_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  edge_0,
    input  logic                                  edge_1,
    input  logic                                  edge_2,
    input  logic                                  tick,
    input  logic                                  start_req,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tcips_pkg::DRIVE_BITS-1:0]      drive_0,
    output logic [tcips_pkg::DRIVE_BITS-1:0]      drive_1,
    output logic [tcips_pkg::DRIVE_BITS-1:0]      drive_2,
    output logic [1:0]                            direction_0,
    output logic [1:0]                            direction_1,
    output logic [1:0]                            direction_2,
    output logic                                  distance_reached
);
    import tcips_pkg::*;

    `include "three_channel_incremental_pid_speed_assert.svh"

    logic signed [CHANNELS-1:0][TARGET_BITS-1:0] target_reg;
    logic [CHANNELS-1:0][LIMIT_BITS-1:0]         limit_reg;

    logic                         load;
    logic [CHANNELS-1:0]          edges;
    lane_stat_t [CHANNELS-1:0]    stat;
    logic                         armed;
    result_t                      res;
    result_t                      res_out;
    logic                         skid_full;

    assign edges = {edge_2, edge_1, edge_0};
    assign load  = in_valid && !in_stall;

    // register writes; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (cfg_index == CFG_IDX_BITS'(c))
                    target_reg[c] <= cfg_data[TARGET_BITS-1:0];
                if (cfg_index == CFG_IDX_BITS'(c + CHANNELS))
                    limit_reg[c] <= cfg_data[LIMIT_BITS-1:0];
            end
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        tcips_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .start    (start_req),
            .tick     (tick),
            .enc_edge (edges[c]),
            .armed    (armed),
            .target   (target_reg[c]),
            .limit    (limit_reg[c]),
            .drive    (res.drive[c]),
            .stat     (stat[c])
        );
    end

    tcips_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .start   (start_req),
        .target  (target_reg),
        .stat    (stat),
        .armed   (armed),
        .dir     (res.dir),
        .reached (res.reached)
    );

    tcips_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res_out),
        .skid_full (skid_full)
    );

    assign in_stall         = skid_full;
    assign drive_0          = res_out.drive[0];
    assign drive_1          = res_out.drive[1];
    assign drive_2          = res_out.drive[2];
    assign direction_0      = res_out.dir[0];
    assign direction_1      = res_out.dir[1];
    assign direction_2      = res_out.dir[2];
    assign distance_reached = res_out.reached;

    // skid entry only fills behind a waiting result
    `TCIPS_ASSERT_IMP(a_skid_behind_main, in_stall, out_valid)

    // a trip stops every channel in the same result
    `TCIPS_ASSERT_IMP(a_trip_stops_all, out_valid && distance_reached,
        direction_0 == DIR_STOP && direction_1 == DIR_STOP && direction_2 == DIR_STOP)

    // a start into an empty output shows cleared drives next cycle
    `TCIPS_ASSERT_NXT(a_start_clears, load && start_req && !out_valid,
        out_valid && drive_0 == '0 && drive_1 == '0 && drive_2 == '0 && !distance_reached)

    // a transferred trip needs a tick and the check armed
    `TCIPS_ASSERT_IMP(a_trip_needs_arm, load && res.reached, tick && armed && !start_req)

endmodule

`default_nettype wire

// ===== src/tcips_lane.sv =====
// One channel: edge counter, incremental PID update and distance compare
`default_nettype none

module tcips_lane #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load,
    input  logic                                      start,
    input  logic                                      tick,
    input  logic                                      enc_edge,
    input  logic                                      armed,
    input  logic signed [tcips_pkg::TARGET_BITS-1:0]  target,
    input  logic [tcips_pkg::LIMIT_BITS-1:0]          limit,
    output logic [tcips_pkg::DRIVE_BITS-1:0]          drive,
    output tcips_pkg::lane_stat_t                     stat
);
    import tcips_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int ERR_W    = COUNT_BITS + 2;

    logic [COUNT_BITS-1:0]          pulse_reg;
    logic [COUNT_BITS-1:0]          last_reg;
    logic signed [ERR_BITS-1:0]     last_err_reg;
    logic signed [ERR_BITS-1:0]     err_sum_reg;
    logic [DRIVE_BITS-1:0]          drive_reg;

    logic [COUNT_BITS-1:0]          pulse_inc;
    logic signed [COUNT_BITS:0]     delta;
    logic signed [TARGET_BITS:0]    tgt_ext;
    logic [TARGET_BITS:0]           mag;
    logic signed [ERR_W-1:0]        err_wide;
    logic signed [ERR_BITS-1:0]     err;
    logic signed [ERR_BITS:0]       sum_wide;
    logic signed [ERR_BITS-1:0]     sum_sat;
    logic signed [ERR_BITS:0]       dif;
    logic signed [ACC_BITS-1:0]     drive_term;
    logic signed [ACC_BITS-1:0]     p_term;
    logic signed [ACC_BITS-1:0]     i_term;
    logic signed [ACC_BITS-1:0]     d_term;
    logic signed [ACC_BITS-1:0]     acc;
    logic [DRIVE_BITS-1:0]          level;
    logic                           over;

    always_comb
    begin
        // saturating count, edges land before the tick
        pulse_inc = (enc_edge && (pulse_reg != '1)) ? pulse_reg + 1'b1 : pulse_reg;
        delta     = $signed({1'b0, pulse_inc}) - $signed({1'b0, last_reg});

        tgt_ext = {target[TARGET_BITS-1], target};
        mag     = tgt_ext[TARGET_BITS] ? unsigned'(-tgt_ext) : unsigned'(tgt_ext);

        err_wide = $signed({{(ERR_W-TARGET_BITS-1){1'b0}}, mag}) - ERR_W'(delta);
        if (err_wide > ERR_W'(ERR_MAX))
            err = ERR_BITS'(ERR_MAX);
        else if (err_wide < ERR_W'(ERR_MIN))
            err = ERR_BITS'(ERR_MIN);
        else
            err = err_wide[ERR_BITS-1:0];

        sum_wide = (ERR_BITS+1)'(err_sum_reg) + (ERR_BITS+1)'(err);
        if (sum_wide > (ERR_BITS+1)'(ERR_MAX))
            sum_sat = ERR_BITS'(ERR_MAX);
        else if (sum_wide < (ERR_BITS+1)'(ERR_MIN))
            sum_sat = ERR_BITS'(ERR_MIN);
        else
            sum_sat = sum_wide[ERR_BITS-1:0];

        dif = (ERR_BITS+1)'(err) - (ERR_BITS+1)'(last_err_reg);

        drive_term = $signed(ACC_BITS'({drive_reg, {FRAC_BITS{1'b0}}}));
        p_term     = err * GAIN_P;
        i_term     = sum_sat * GAIN_I;
        d_term     = dif * GAIN_D;
        acc        = drive_term + p_term + i_term + d_term;

        // truncation toward zero: a negative sum always clamps to zero
        if (acc[ACC_BITS-1])
            level = '0;
        else if (|acc[ACC_BITS-2:FRAC_BITS+DRIVE_BITS])
            level = DRIVE_MAX;
        else
            level = acc[FRAC_BITS+DRIVE_BITS-1:FRAC_BITS];

        over = armed && (CMP_BITS'(pulse_inc) > CMP_BITS'(limit));

        stat.trip = tick && !start && over;

        if (start)
            drive = '0;
        else if (tick)
            drive = level;
        else
            drive = drive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg    <= '0;
            last_reg     <= '0;
            last_err_reg <= '0;
            err_sum_reg  <= '0;
            drive_reg    <= '0;
        end
        else if (load)
        begin
            if (start)
            begin
                pulse_reg    <= '0;
                last_reg     <= '0;
                last_err_reg <= '0;
                err_sum_reg  <= '0;
                drive_reg    <= '0;
            end
            else if (tick)
            begin
                last_reg     <= pulse_inc;
                last_err_reg <= err;
                err_sum_reg  <= sum_sat;
                drive_reg    <= level;
                // drop the count on a trip, keep the tick snapshot
                pulse_reg    <= over ? '0 : pulse_inc;
            end
            else
            begin
                pulse_reg <= pulse_inc;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tcips_merge.sv =====
// Merge of lane trip flags: arm state, directions and distance flag
`default_nettype none

module tcips_merge (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      load,
    input  logic                                                      start,
    input  logic signed [tcips_pkg::CHANNELS-1:0][tcips_pkg::TARGET_BITS-1:0] target,
    input  tcips_pkg::lane_stat_t [tcips_pkg::CHANNELS-1:0]           stat,
    output logic                                                      armed,
    output tcips_pkg::dir_t [tcips_pkg::CHANNELS-1:0]                 dir,
    output logic                                                      reached
);
    import tcips_pkg::*;

    logic                   armed_reg;
    dir_t [CHANNELS-1:0]    dir_reg;
    dir_t [CHANNELS-1:0]    dir_next;
    logic                   armed_next;
    logic                   tripped;

    always_comb
    begin
        tripped = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            tripped = tripped | stat[c].trip;

        armed_next = armed_reg;
        dir_next   = dir_reg;
        if (start)
        begin
            armed_next = 1'b1;
            for (int c = 0; c < CHANNELS; c++)
                dir_next[c] = dir_of(target[c]);
        end
        else if (tripped)
        begin
            armed_next = 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                dir_next[c] = DIR_STOP;
        end
    end

    assign armed   = armed_reg;
    assign dir     = dir_next;
    assign reached = tripped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                dir_reg[c] <= DIR_STOP;
        end
        else if (load)
        begin
            armed_reg <= armed_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tcips_outbuf.sv =====
// Result register with one skid entry
`default_nettype none

module tcips_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  tcips_pkg::result_t    res_in,
    input  logic                  out_stall,
    output logic                  out_valid,
    output tcips_pkg::result_t    res_out,
    output logic                  skid_full
);
    import tcips_pkg::*;

    logic       main_valid_reg;
    logic       skid_valid_reg;
    result_t    main_reg;
    result_t    skid_reg;
    logic       drain;
    logic       to_main;

    assign drain   = main_valid_reg && !out_stall;
    assign to_main = !main_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (to_main)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            // advance the skid entry, if any
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && to_main)
            main_reg <= res_in;
        else if (load)
            skid_reg <= res_in;
        else if (drain && skid_valid_reg)
            main_reg <= skid_reg;
    end

    assign out_valid = main_valid_reg;
    assign res_out   = main_reg;
    assign skid_full = skid_valid_reg;

endmodule

`default_nettype wire
